[hw/rtl/sgdr_pkg.sv]
// Package for the sandpile grain drop and relax unit.
// Holds field widths, operation and neighbor codes, and the controller-datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps

package sgdr_pkg;

  localparam int unsigned OPCODE_W      = 1;
  localparam int unsigned ROW_W         = 4;
  localparam int unsigned COL_W         = 4;
  localparam int unsigned CELL_W        = 4;
  localparam int unsigned COUNT_W       = 16;
  localparam int unsigned TOPPLE_LIMIT  = 4;
  localparam int unsigned GRID_SIDE_DEF = 16;

  // Operation codes carried in the opcode field.
  localparam logic [OPCODE_W-1:0] OP_DROP = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

  // Neighbor visit order around a toppling cell.
  typedef enum logic [1:0] {
    NB_UP    = 2'd0,
    NB_DOWN  = 2'd1,
    NB_LEFT  = 2'd2,
    NB_RIGHT = 2'd3
  } nb_t;

  // Source of the grid memory address.
  typedef enum logic [1:0] {
    ADDR_CLR = 2'd0,
    ADDR_TGT = 2'd1,
    ADDR_CUR = 2'd2,
    ADDR_NB  = 2'd3
  } addr_sel_t;

  // Source of the grid memory write data.
  typedef enum logic [1:0] {
    WD_ZERO = 2'd0,
    WD_INC  = 2'd1,
    WD_DEC4 = 2'd2
  } wdata_sel_t;

  typedef struct packed {
    logic       clr_step;
    logic       accept;
    addr_sel_t  addr_sel;
    logic       mem_re;
    logic       mem_we;
    wdata_sel_t wdata_sel;
    logic       scan_start;
    logic       scan_next;
    logic       topple;
    logic       nb_next;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_of_range;
    logic op_read;
    logic ge4;
    logic scan_last;
    logic moved;
    logic nb_valid;
    logic nb_last;
    logic out_busy;
  } status_t;

endpackage

[hw/rtl/sgdr_req_if.sv]
// Request channel of the sandpile unit: one operation per beat.
// Depends on sgdr_pkg for field widths.
`timescale 1ns / 1ps

interface sgdr_req_if;
  logic                          valid;
  logic                          ready;
  logic [sgdr_pkg::OPCODE_W-1:0] opcode;
  logic [sgdr_pkg::ROW_W-1:0]    row;
  logic [sgdr_pkg::COL_W-1:0]    col;

  modport source (output valid, output opcode, output row, output col, input ready);
  modport sink (input valid, input opcode, input row, input col, output ready);
endinterface

// Response channel of the sandpile unit: one result per beat.
interface sgdr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sgdr_pkg::COUNT_W-1:0] topple_count;
  logic [sgdr_pkg::CELL_W-1:0]  cell_value;
  logic                         ignored;

  modport source (output valid, output topple_count, output cell_value, output ignored,
                  input ready);
  modport sink (input valid, input topple_count, input cell_value, input ignored,
                output ready);
endinterface

[hw/rtl/sgdr_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sgdr_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[hw/rtl/sgdr_ctrl.sv]
// Sequencer of the sandpile unit: clearing pass, drop, scan passes, neighbor updates.
// Depends on sgdr_pkg; drives the datapath through cmd_t and watches status_t.
`timescale 1ns / 1ps

module sgdr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sgdr_pkg::status_t status,
  output sgdr_pkg::cmd_t    cmd
);

  import sgdr_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_DECODE   = 11'b000_0000_0100,
    S_DROP_RD  = 11'b000_0000_1000,
    S_DROP_WR  = 11'b000_0001_0000,
    S_SCAN_RD  = 11'b000_0010_0000,
    S_SCAN_CHK = 11'b000_0100_0000,
    S_NB_RD    = 11'b000_1000_0000,
    S_NB_WR    = 11'b001_0000_0000,
    S_FIN_RD   = 11'b010_0000_0000,
    S_RES      = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;
  logic   advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    advance    = 1'b0;

    unique case (state)
      S_CLEAR: begin
        cmd.clr_step  = 1'b1;
        cmd.addr_sel  = ADDR_CLR;
        cmd.mem_we    = 1'b1;
        cmd.mem_re    = 1'b1;
        cmd.wdata_sel = WD_ZERO;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.out_of_range) begin
          state_next = S_RES;
        end else if (status.op_read) begin
          state_next = S_FIN_RD;
        end else begin
          state_next = S_DROP_RD;
        end
      end
      S_DROP_RD: begin
        cmd.addr_sel = ADDR_TGT;
        cmd.mem_re   = 1'b1;
        state_next   = S_DROP_WR;
      end
      S_DROP_WR: begin
        cmd.addr_sel   = ADDR_TGT;
        cmd.mem_re     = 1'b1;
        cmd.mem_we     = 1'b1;
        cmd.wdata_sel  = WD_INC;
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.addr_sel = ADDR_CUR;
        cmd.mem_re   = 1'b1;
        state_next   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (status.ge4) begin
          cmd.addr_sel  = ADDR_CUR;
          cmd.mem_re    = 1'b1;
          cmd.mem_we    = 1'b1;
          cmd.wdata_sel = WD_DEC4;
          cmd.topple    = 1'b1;
          state_next    = S_NB_RD;
        end else begin
          advance = 1'b1;
        end
      end
      S_NB_RD: begin
        if (status.nb_valid) begin
          cmd.addr_sel = ADDR_NB;
          cmd.mem_re   = 1'b1;
          state_next   = S_NB_WR;
        end else if (status.nb_last) begin
          advance = 1'b1;
        end else begin
          cmd.nb_next = 1'b1;
        end
      end
      S_NB_WR: begin
        cmd.addr_sel  = ADDR_NB;
        cmd.mem_re    = 1'b1;
        cmd.mem_we    = 1'b1;
        cmd.wdata_sel = WD_INC;
        if (status.nb_last) begin
          advance = 1'b1;
        end else begin
          cmd.nb_next = 1'b1;
          state_next  = S_NB_RD;
        end
      end
      S_FIN_RD: begin
        cmd.addr_sel = ADDR_TGT;
        cmd.mem_re   = 1'b1;
        state_next   = S_RES;
      end
      S_RES: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase

    // Step to the next cell of the scan, or start another pass if anything toppled.
    if (advance) begin
      if (!status.scan_last) begin
        cmd.scan_next = 1'b1;
        state_next    = S_SCAN_RD;
      end else if (status.moved) begin
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN_RD;
      end else begin
        state_next = S_FIN_RD;
      end
    end
  end

endmodule

[hw/rtl/sgdr_dpath.sv]
// Datapath of the sandpile unit: grid memory, scan and neighbor addressing,
// topple counter and result register. Depends on sgdr_pkg, sgdr_ram, sgdr_rsp_if.
`timescale 1ns / 1ps

module sgdr_dpath #(
  parameter int unsigned GRID_SIDE = sgdr_pkg::GRID_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sgdr_pkg::cmd_t                cmd,
  output sgdr_pkg::status_t             status,
  input  logic [sgdr_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [sgdr_pkg::ROW_W-1:0]    in_row,
  input  logic [sgdr_pkg::COL_W-1:0]    in_col,
  sgdr_rsp_if.source                    rsp
);

  import sgdr_pkg::*;

  localparam int unsigned CW    = $clog2(GRID_SIDE);
  localparam int unsigned AW    = 2 * CW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);

  logic [OPCODE_W-1:0] opcode;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic [AW-1:0]       clr_addr;
  logic [CW-1:0]       cur_row, cur_col;
  logic                moved;
  nb_t                 nb;
  logic [COUNT_W-1:0]  count;
  logic                out_valid;

  logic [CW-1:0]     tgt_row, tgt_col, nb_row, nb_col;
  logic              nb_valid;
  logic [AW-1:0]     mem_addr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;
  logic              out_of_range;

  // Latched operation and its target.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      opcode <= in_opcode;
      row    <= in_row;
      col    <= in_col;
    end
  end

  assign out_of_range = (32'(row) >= GRID_SIDE) || (32'(col) >= GRID_SIDE);
  assign tgt_row      = CW'(row);
  assign tgt_col      = CW'(col);

  // Neighbor of the cell under the scan.
  always_comb begin
    nb_row   = cur_row;
    nb_col   = cur_col;
    nb_valid = 1'b0;
    case (nb)
      NB_UP: begin
        nb_row   = cur_row - 1'b1;
        nb_valid = (cur_row != '0);
      end
      NB_DOWN: begin
        nb_row   = cur_row + 1'b1;
        nb_valid = (cur_row != LAST);
      end
      NB_LEFT: begin
        nb_col   = cur_col - 1'b1;
        nb_valid = (cur_col != '0);
      end
      NB_RIGHT: begin
        nb_col   = cur_col + 1'b1;
        nb_valid = (cur_col != LAST);
      end
      default: nb_valid = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_CLR: mem_addr = clr_addr;
      ADDR_TGT: mem_addr = {tgt_row, tgt_col};
      ADDR_CUR: mem_addr = {cur_row, cur_col};
      ADDR_NB:  mem_addr = {nb_row, nb_col};
      default:  mem_addr = clr_addr;
    endcase
  end

  always_comb begin
    unique case (cmd.wdata_sel)
      WD_ZERO: mem_wdata = '0;
      WD_INC:  mem_wdata = mem_rdata + CELL_W'(1);
      WD_DEC4: mem_wdata = mem_rdata - CELL_W'(TOPPLE_LIMIT);
      default: mem_wdata = '0;
    endcase
  end

  sgdr_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .en    (cmd.mem_re),
    .we    (cmd.mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Scan position, pass activity, neighbor step and topple count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
      moved   <= 1'b0;
      nb      <= NB_UP;
      count   <= '0;
    end else begin
      if (cmd.accept) begin
        count <= '0;
      end
      if (cmd.scan_start) begin
        cur_row <= '0;
        cur_col <= '0;
        moved   <= 1'b0;
      end else if (cmd.scan_next) begin
        if (cur_col == LAST) begin
          cur_col <= '0;
          cur_row <= cur_row + 1'b1;
        end else begin
          cur_col <= cur_col + 1'b1;
        end
      end
      if (cmd.topple) begin
        moved <= 1'b1;
        nb    <= NB_UP;
        if (count != '1) begin
          count <= count + 1'b1;
        end
      end else if (cmd.nb_next) begin
        nb <= nb_t'(nb + 2'd1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.topple_count <= out_of_range ? '0 : count;
      rsp.cell_value   <= out_of_range ? '0 : mem_rdata;
      rsp.ignored      <= out_of_range;
    end
  end

  assign rsp.valid = out_valid;

  assign status.clear_last   = (clr_addr == '1);
  assign status.out_of_range = out_of_range;
  assign status.op_read      = (opcode == OP_READ);
  assign status.ge4          = (mem_rdata >= CELL_W'(TOPPLE_LIMIT));
  assign status.scan_last    = (cur_row == LAST) && (cur_col == LAST);
  assign status.moved        = moved;
  assign status.nb_valid     = nb_valid;
  assign status.nb_last      = (nb == NB_RIGHT);
  assign status.out_busy     = out_valid && !rsp.ready;

endmodule

[hw/rtl/sandpile_grain_drop_relax_unit.sv]
// Top level of the sandpile grain drop and relax unit.
// Depends on sgdr_pkg, sgdr_req_if, sgdr_rsp_if, sgdr_ram, sgdr_ctrl and sgdr_dpath.
`timescale 1ns / 1ps

// The unit keeps a GRID_SIDE x GRID_SIDE abelian sandpile in a single-port RAM
// of 4-bit cells, addressed as {row, col} and padded to a power-of-two depth.
// After reset a clearing pass writes zero to every RAM word, one word a cycle;
// no request is taken until it ends. Each request beat carries one operation.
// A read steps through the accepting cycle, decode, one RAM read, and the
// result load, which waits while the output register is busy. An ignored
// beat skips the RAM read. A drop adds one grain to the target cell and then
// scans the whole grid in passes. Every scan visit is a read and a check; a
// cell holding four or more grains topples once per visit. Its own write
// happens in the check step, and each neighbor then takes a read and a write
// when it lies inside the grid, or is just passed over when it lies off the
// edge. Passes repeat until one pass sees no toppling, so a quiet drop costs
// one full pass and an avalanche adds one full pass per round of spreading
// plus the per-topple cost. The single RAM port sets all of these costs.
// Coordinates outside the grid produce a result with the ignored flag set and
// zero fields, without touching the grid. The topple count saturates at 65535
// while the grid still relaxes fully. The result sits in an output register,
// so the next request beat is taken while the previous result still waits for
// its response beat.

module sandpile_grain_drop_relax_unit #(
  parameter int unsigned GRID_SIDE = sgdr_pkg::GRID_SIDE_DEF
) (
  input logic       clk,
  input logic       rst,
  sgdr_req_if.sink  req,
  sgdr_rsp_if.source rsp
);

  import sgdr_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // The sequencer owns request acceptance; the datapath owns the response beat.
  sgdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sgdr_dpath #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_opcode (req.opcode),
    .in_row    (req.row),
    .in_col    (req.col),
    .rsp       (rsp)
  );

  assign req.ready = in_ready;

  // A result is only loaded when the output register is free to take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !status.out_busy)
    else $error("result loaded over a pending response beat");

  // One operation at a time: no request is taken right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && in_ready |=> !in_ready)
    else $error("request taken while an operation is in progress");

  // An ignored operation reports no topplings and no cell value.
  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ignored |-> rsp.topple_count == '0 && rsp.cell_value == '0)
    else $error("ignored result carries nonzero fields");

  // Once relaxed, every reported cell holds fewer than four grains.
  a_relaxed: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ignored |-> rsp.cell_value < CELL_W'(TOPPLE_LIMIT))
    else $error("reported cell is not relaxed");

endmodule

[tb/sv/sgdr_pile_checker.sv]
// Scoreboard for the sandpile grain drop and relax unit: watches both channels,
// keeps its own copy of the grain grid and checks every response beat.
// Depends on sgdr_pkg, sgdr_req_if and sgdr_rsp_if.
`timescale 1ns / 1ps

module sgdr_pile_checker #(
  parameter int unsigned GRID_SIDE = sgdr_pkg::GRID_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sgdr_req_if         req,
  sgdr_rsp_if         rsp,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  import sgdr_pkg::*;

  localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;

  typedef struct packed {
    logic [COUNT_W-1:0] topples;
    logic [CELL_W-1:0]  grains;
    logic               off_grid;
  } pile_outcome_t;

  int unsigned   grains_at [GRID_SIDE][GRID_SIDE];
  pile_outcome_t pending_outcomes [$];

  // Applies one operation to the grid copy. A drop relaxes the grid row by row,
  // toppling each unstable cell as often as it needs; the total is the same in
  // any scan order, so the count and the grid can be matched to the hardware.
  function automatic pile_outcome_t pile_outcome(input logic [OPCODE_W-1:0] op,
                                                 input logic [ROW_W-1:0]    r,
                                                 input logic [COL_W-1:0]    c);
    pile_outcome_t res;
    int unsigned   total;
    int unsigned   n;
    bit            unstable;
    res = '0;
    if (r >= GRID_SIDE || c >= GRID_SIDE) begin
      res.off_grid = 1'b1;
      return res;
    end
    total = 0;
    if (op == OP_DROP) begin
      grains_at[r][c] += 1;
      unstable = 1'b1;
      while (unstable) begin
        unstable = 1'b0;
        for (int y = 0; y < GRID_SIDE; y++) begin
          for (int x = 0; x < GRID_SIDE; x++) begin
            if (grains_at[y][x] >= TOPPLE_LIMIT) begin
              n = grains_at[y][x] / TOPPLE_LIMIT;
              grains_at[y][x] -= n * TOPPLE_LIMIT;
              if (y > 0) grains_at[y-1][x] += n;
              if (y + 1 < GRID_SIDE) grains_at[y+1][x] += n;
              if (x > 0) grains_at[y][x-1] += n;
              if (x + 1 < GRID_SIDE) grains_at[y][x+1] += n;
              total = (total + n > COUNT_MAX) ? COUNT_MAX : total + n;
              unstable = 1'b1;
            end
          end
        end
      end
    end
    res.topples = total[COUNT_W-1:0];
    res.grains  = grains_at[r][c][CELL_W-1:0];
    return res;
  endfunction

  // Responses are checked before the new request is predicted, so a stray
  // response can never consume an expectation pushed in the same cycle.
  always @(posedge clk) begin : watch_beats
    pile_outcome_t want;
    if (rst) begin
      foreach (grains_at[y, x]) grains_at[y][x] = 0;
      pending_outcomes.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("response beat with no request waiting: topple_count %0d cell_value %0d",
                 rsp.topple_count, rsp.cell_value);
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp.topple_count !== want.topples) begin
            $error("topple_count: expected %0d, got %0d", want.topples, rsp.topple_count);
            mismatches++;
          end
          if (rsp.cell_value !== want.grains) begin
            $error("cell_value: expected %0d, got %0d", want.grains, rsp.cell_value);
            mismatches++;
          end
          if (rsp.ignored !== want.off_grid) begin
            $error("ignored: expected %0d, got %0d", want.off_grid, rsp.ignored);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_outcomes.push_back(pile_outcome(req.opcode, req.row, req.col));
      end
      outstanding = pending_outcomes.size();
    end
  end

endmodule

[tb/sv/sandpile_grain_drop_relax_unit_tb.sv]
// Top of the testbench for the sandpile grain drop and relax unit: clock, reset,
// request stimulus, response back-pressure and the final verdict.
// Depends on sgdr_pkg, sgdr_req_if, sgdr_rsp_if, sgdr_pile_checker and the unit.
`timescale 1ns / 1ps

module sandpile_grain_drop_relax_unit_tb;
  import sgdr_pkg::*;

  // The default 16 x 16 grid. Every 4-bit coordinate then lies on the grid,
  // so no beat is ignored and the RAM has no padding words.
  localparam int unsigned GRID_SIDE  = GRID_SIDE_DEF;
  localparam int unsigned RANDOM_OPS = 1830;
  localparam int unsigned PHASE_OPS  = RANDOM_OPS / 3;
  localparam int unsigned LAST       = GRID_SIDE - 1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned send_idle_pct;
  int unsigned take_idle_pct;
  int unsigned mismatches;
  int unsigned outstanding;

  sgdr_req_if req ();
  sgdr_rsp_if rsp ();

  sandpile_grain_drop_relax_unit #(
    .GRID_SIDE(GRID_SIDE)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // The scoreboard sits beside the unit and only observes the two channels.
  sgdr_pile_checker #(
    .GRID_SIDE(GRID_SIDE)
  ) i_pile_checker (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  // 12 ns period: six nanoseconds high, six low.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Response back-pressure. Ready is redrawn at every rising edge, exactly one
  // nonblocking update per edge, from the stall rate of the current phase.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // Presents one request beat, after a random number of idle cycles, and
  // returns at the edge that accepts it. Valid stays high into the next call
  // when that call draws no idle cycle, so it is never dropped and raised
  // again within one time step. Coordinates are cut to the field width here.
  task automatic send_op(input logic [OPCODE_W-1:0] op,
                         input int unsigned         r,
                         input int unsigned         c);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.opcode <= op;
    req.row    <= ROW_W'(r);
    req.col    <= COL_W'(c);
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  initial begin
    int unsigned pick;
    req.valid     <= 1'b0;
    req.opcode    <= OP_DROP;
    req.row       <= '0;
    req.col       <= '0;
    send_idle_pct = 0;
    take_idle_pct = 0;

    // Synchronous reset comes first. The unit then clears its RAM on its own and
    // keeps ready low until that pass is over.
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Reads of an empty grid at opposite corners come first.
    send_op(OP_READ, 0, 0);
    send_op(OP_READ, LAST, LAST);
    // Four grains on a corner: the fourth topples it, and two grains fall off
    // the edge while the two inner neighbors get one each.
    repeat (4) send_op(OP_DROP, 0, 0);
    send_op(OP_READ, 0, 1);
    // Beats at the field extremes, on either field and for both operations.
    // On the full grid they all land on edge cells of the pile.
    send_op(OP_DROP, 15, 15);
    send_op(OP_READ, 15, 3);
    send_op(OP_DROP, 2, 15);
    send_op(OP_READ, LAST, 0);
    send_op(OP_DROP, 0, LAST);
    // The far corner, then an inner cell that loses all four grains inward.
    repeat (4) send_op(OP_DROP, LAST, LAST);
    repeat (4) send_op(OP_DROP, 5, 6);
    send_op(OP_READ, 5, 7);
    send_op(OP_DROP, 0, LAST);
    send_op(OP_READ, LAST, 0);

    // Random part in three phases of back-pressure: a mostly stalled receiver,
    // then a mostly idle sender, then full rate on both sides. Most requests
    // are drops so the pile climbs to its critical density and large
    // avalanches follow; reads check the cells in between, and a share of
    // fully random beats covers every opcode and coordinate bit.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 6;
          take_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          take_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      repeat (PHASE_OPS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_op(OP_DROP, $urandom_range(LAST), $urandom_range(LAST));
        end else if (pick < 85) begin
          send_op(OP_READ, $urandom_range(LAST), $urandom_range(LAST));
        end else begin
          send_op(OPCODE_W'($urandom), $urandom, $urandom);
        end
      end
    end
    req.valid <= 1'b0;

    // Drain: wait until every request has its response, then leave a short
    // margin so that a stray extra beat would still be seen.
    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS sandpile_grain_drop_relax_unit");
    end else begin
      $display("FAIL sandpile_grain_drop_relax_unit");
    end
    $finish;
  end

  // Watchdog. Its bound covers every request at the worst avalanche a 16 x 16
  // pile allows, with back-pressure, several times over.
  initial begin
    repeat (2000) #25_000_000;
    $display("FAIL sandpile_grain_drop_relax_unit");
    $finish;
  end

endmodule
